// ===== src/sensor_average_zone_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SENSOR_AVERAGE_ZONE_CLASSIFIER_CORE_DEFINES_SVH
`define SENSOR_AVERAGE_ZONE_CLASSIFIER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAZC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAZC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== src/sazc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier: package
// Widths, register indexes, zone codes and controller interface types.
// ----------------------------------------------------------------------------
package sazc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int ACC_BITS    = SAMPLE_BITS + 8;
    localparam int CNT_BITS    = $clog2(ACC_BITS + 1);
    localparam int RES_BITS    = 16;
    localparam int ZONE_BITS   = 3;
    localparam int COUNT_BITS  = 8;
    localparam int INDEX_BITS  = 3;

    localparam logic [INDEX_BITS-1:0] REG_SAMPLE_COUNT    = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_NUMERATOR       = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_UPPER_THRESHOLD = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_LOWER_THRESHOLD = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_WET_VALUE       = 3'd4;

    localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RESET    = 8'd80;
    localparam logic [RES_BITS-1:0]   NUMERATOR_RESET       = 16'd47000;
    localparam logic [RES_BITS-1:0]   UPPER_THRESHOLD_RESET = 16'd300;
    localparam logic [RES_BITS-1:0]   LOWER_THRESHOLD_RESET = 16'd200;
    localparam logic [RES_BITS-1:0]   WET_VALUE_RESET       = 16'd231;
    localparam logic [RES_BITS-1:0]   RES_SATURATED         = 16'hFFFF;

    localparam logic [ZONE_BITS-1:0] ZONE_NONE    = 3'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_WET     = 3'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_SAFE    = 3'd2;
    localparam logic [ZONE_BITS-1:0] ZONE_WARNING = 3'd3;
    localparam logic [ZONE_BITS-1:0] ZONE_DANGER  = 3'd4;

    typedef struct packed {
        logic add_sample;
        logic start_avg;
        logic capture_avg;
        logic start_res;
        logic finish;
    } sazc_cmd_t;

    typedef struct packed {
        logic window_full;
        logic div_done;
        logic avg_zero;
    } sazc_status_t;

endpackage

// ===== src/sazc_divider.sv =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier: divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sazc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sazc_pkg::ACC_BITS-1:0] dividend,
    input  logic [sazc_pkg::ACC_BITS-1:0] divisor,
    output logic [sazc_pkg::ACC_BITS-1:0] quotient,
    output logic                          done
);
    import sazc_pkg::*;

    logic [ACC_BITS-1:0] rem_reg;
    logic [ACC_BITS-1:0] quo_reg;
    logic [ACC_BITS-1:0] divisor_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ACC_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[ACC_BITS-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_BITS'(ACC_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= ACC_BITS'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[ACC_BITS-1:0];
            end
            quo_reg <= {quo_reg[ACC_BITS-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== src/sazc_datapath.sv =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier: datapath
// Configuration registers, accumulator, shared divider, resistance history,
// zone selection and the result register.
// ----------------------------------------------------------------------------
module sazc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [sazc_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [sazc_pkg::RES_BITS-1:0]    cfg_data,
    input  logic [sazc_pkg::SAMPLE_BITS-1:0] sample,
    input  sazc_pkg::sazc_cmd_t              cmd,
    output sazc_pkg::sazc_status_t           status,
    output logic [sazc_pkg::SAMPLE_BITS-1:0] average,
    output logic [sazc_pkg::RES_BITS-1:0]    resistance,
    output logic [sazc_pkg::ZONE_BITS-1:0]   zone
);
    import sazc_pkg::*;

    logic [COUNT_BITS-1:0]  sample_count_reg;
    logic [RES_BITS-1:0]    numerator_reg;
    logic [RES_BITS-1:0]    upper_threshold_reg;
    logic [RES_BITS-1:0]    lower_threshold_reg;
    logic [RES_BITS-1:0]    wet_value_reg;
    logic [COUNT_BITS-1:0]  sample_counter_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [RES_BITS-1:0]    prior_res_reg;
    logic [RES_BITS-1:0]    older_res_reg;
    logic [ACC_BITS-1:0]    avg_reg;
    logic [SAMPLE_BITS-1:0] average_reg;
    logic [RES_BITS-1:0]    resistance_reg;
    logic [ZONE_BITS-1:0]   zone_reg;
    logic [ACC_BITS-1:0]    div_dividend;
    logic [ACC_BITS-1:0]    div_divisor;
    logic [ACC_BITS-1:0]    div_quotient;
    logic                   div_done;
    logic                   div_start;
    logic [RES_BITS-1:0]    res_value;
    logic [ZONE_BITS-1:0]   zone_value;
    logic                   avg_zero;

    function automatic logic above_band(input logic [RES_BITS-1:0] r,
                                        input logic [RES_BITS-1:0] upper);
        return r > upper;
    endfunction

    function automatic logic mid_band(input logic [RES_BITS-1:0] r,
                                      input logic [RES_BITS-1:0] upper,
                                      input logic [RES_BITS-1:0] lower);
        return (r > lower) && (r < upper);
    endfunction

    function automatic logic below_band(input logic [RES_BITS-1:0] r,
                                        input logic [RES_BITS-1:0] lower);
        return r < lower;
    endfunction

    assign div_start    = cmd.start_avg || cmd.start_res;
    assign div_dividend = cmd.start_avg ? acc_reg : ACC_BITS'(numerator_reg);
    assign div_divisor  = cmd.start_avg ? ACC_BITS'({1'b0, sample_count_reg} + 9'd1)
                                        : avg_reg;

    sazc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign avg_zero  = (avg_reg == '0);
    assign res_value = avg_zero ? RES_SATURATED : div_quotient[RES_BITS-1:0];

    always_comb
    begin
        priority if (res_value == wet_value_reg)
        begin
            zone_value = ZONE_WET;
        end
        else if (above_band(res_value, upper_threshold_reg)
                 && above_band(prior_res_reg, upper_threshold_reg)
                 && above_band(older_res_reg, upper_threshold_reg))
        begin
            zone_value = ZONE_SAFE;
        end
        else if (mid_band(res_value, upper_threshold_reg, lower_threshold_reg)
                 && mid_band(prior_res_reg, upper_threshold_reg, lower_threshold_reg)
                 && mid_band(older_res_reg, upper_threshold_reg, lower_threshold_reg))
        begin
            zone_value = ZONE_WARNING;
        end
        else if (below_band(res_value, lower_threshold_reg)
                 && below_band(prior_res_reg, lower_threshold_reg)
                 && below_band(older_res_reg, lower_threshold_reg))
        begin
            zone_value = ZONE_DANGER;
        end
        else
        begin
            zone_value = ZONE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg    <= SAMPLE_COUNT_RESET;
            numerator_reg       <= NUMERATOR_RESET;
            upper_threshold_reg <= UPPER_THRESHOLD_RESET;
            lower_threshold_reg <= LOWER_THRESHOLD_RESET;
            wet_value_reg       <= WET_VALUE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT:    sample_count_reg    <= cfg_data[COUNT_BITS-1:0];
                REG_NUMERATOR:       numerator_reg       <= cfg_data;
                REG_UPPER_THRESHOLD: upper_threshold_reg <= cfg_data;
                REG_LOWER_THRESHOLD: lower_threshold_reg <= cfg_data;
                REG_WET_VALUE:       wet_value_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_counter_reg <= '0;
            acc_reg            <= '0;
            prior_res_reg      <= '0;
            older_res_reg      <= '0;
        end
        else
        begin
            if (cmd.add_sample)
            begin
                acc_reg            <= acc_reg + ACC_BITS'(sample);
                sample_counter_reg <= sample_counter_reg + 1'b1;
            end
            if (cmd.capture_avg)
            begin
                acc_reg <= div_quotient;
            end
            if (cmd.finish)
            begin
                sample_counter_reg <= '0;
                older_res_reg      <= prior_res_reg;
                prior_res_reg      <= res_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_avg)
        begin
            avg_reg <= div_quotient;
        end
        if (cmd.finish)
        begin
            average_reg    <= avg_reg[SAMPLE_BITS-1:0];
            resistance_reg <= res_value;
            zone_reg       <= zone_value;
        end
    end

    assign status.window_full = (sample_counter_reg >= sample_count_reg);
    assign status.div_done    = div_done;
    assign status.avg_zero    = avg_zero;

    assign average    = average_reg;
    assign resistance = resistance_reg;
    assign zone       = zone_reg;

endmodule

// ===== src/sazc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier: controller
// Sequences accumulation, the two divisions and the result hand-off.
// ----------------------------------------------------------------------------
module sazc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  sazc_pkg::sazc_status_t status,
    output sazc_pkg::sazc_cmd_t    cmd
);
    import sazc_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_AVG = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_DIV_RES = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       accept;

    assign sample_stall = !((state_reg == ST_IDLE)
                            && (!status.window_full || !result_valid_reg));
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.window_full)
                    begin
                        cmd.start_avg = 1'b1;
                        state_next    = ST_DIV_AVG;
                    end
                    else
                    begin
                        cmd.add_sample = 1'b1;
                    end
                end
            end
            ST_DIV_AVG:
            begin
                if (status.div_done)
                begin
                    cmd.capture_avg = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.avg_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start_res = 1'b1;
                    state_next    = ST_DIV_RES;
                end
            end
            ST_DIV_RES:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.finish)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// ===== src/sensor_average_zone_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Sensor average zone classifier core
// Averages converter samples over a window and classifies the resistance.
// ----------------------------------------------------------------------------
// A sample word enters on sample/sample_valid and is taken when sample_stall
// is low. Result words leave on average/resistance/zone with result_valid and
// are taken when result_stall is low. Configuration words are written on
// cfg_valid, cfg_index and cfg_data; cfg_ready is always high.
// A sample that only adds to the window leaves the controller idle, so such
// samples may arrive back to back. The sample that completes a window starts
// two passes of one shared restoring divider, and its result word appears
// after the second pass, or after the first when the average is zero and
// the second pass is skipped; no sample is taken meanwhile. While a result
// word waits under result_stall, further samples that only add to the window
// are still taken, but a completing sample is held off until the waiting
// word has gone.
// Reset clears the accumulator, the counter, the resistance history and the
// result valid flag, and returns the registers to their default values.
// ----------------------------------------------------------------------------
module sensor_average_zone_classifier_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sazc_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [sazc_pkg::RES_BITS-1:0]    cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [sazc_pkg::SAMPLE_BITS-1:0] sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [sazc_pkg::SAMPLE_BITS-1:0] average,
    output logic [sazc_pkg::RES_BITS-1:0]    resistance,
    output logic [sazc_pkg::ZONE_BITS-1:0]   zone
);
    import sazc_pkg::*;

    `include "sensor_average_zone_classifier_core_defines.svh"

    sazc_cmd_t    cmd;
    sazc_status_t status;

    assign cfg_ready = 1'b1;

    sazc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sazc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .cmd        (cmd),
        .status     (status),
        .average    (average),
        .resistance (resistance),
        .zone       (zone)
    );

    `SAZC_ASSERT_SAME(a_no_completion_while_pending,
        sample_valid && !sample_stall && result_valid, !status.window_full)
    `SAZC_ASSERT_NEXT(a_finish_raises_valid, cmd.finish, result_valid)
    `SAZC_ASSERT_NEXT(a_zero_average_saturates,
        cmd.finish && status.avg_zero, resistance == RES_SATURATED)
    `SAZC_ASSERT_NEXT(a_completion_starts_division,
        sample_valid && !sample_stall && status.window_full, sample_stall)

endmodule

// ===== dv/sensor_average_zone_classifier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor average zone classifier core: testbench
// Sends sample words, keeps its own running model of the averaging window,
// the resistance history and the zone rule, and checks every result word in
// order. A short directed part covers saturation, field extremes, every zone,
// overlapping bands, a zero sample count and a counter left past the count.
// Randomised register settings and level-driven windows follow.
// ----------------------------------------------------------------------------
module sensor_average_zone_classifier_core_test;

    import sazc_pkg::*;

    localparam int ITEM_TARGET    = 1950;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [INDEX_BITS-1:0] REG_SPARE_FIRST = REG_WET_VALUE + 1'b1;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic [RES_BITS-1:0]    resistance;
        logic [ZONE_BITS-1:0]   zone;
    } window_word_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [INDEX_BITS-1:0]  cfg_index    = '0;
    logic [RES_BITS-1:0]    cfg_data     = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic [SAMPLE_BITS-1:0] sample       = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [SAMPLE_BITS-1:0] average;
    logic [RES_BITS-1:0]    resistance;
    logic [ZONE_BITS-1:0]   zone;

    logic [COUNT_BITS-1:0]  set_count     = SAMPLE_COUNT_RESET;
    logic [RES_BITS-1:0]    set_numerator = NUMERATOR_RESET;
    logic [RES_BITS-1:0]    set_upper     = UPPER_THRESHOLD_RESET;
    logic [RES_BITS-1:0]    set_lower     = LOWER_THRESHOLD_RESET;
    logic [RES_BITS-1:0]    set_wet       = WET_VALUE_RESET;
    logic [COUNT_BITS-1:0]  win_count     = '0;
    logic [ACC_BITS-1:0]    win_sum       = '0;
    logic [RES_BITS-1:0]    res_one_back  = '0;
    logic [RES_BITS-1:0]    res_two_back  = '0;

    window_word_t pending_windows[$];
    window_word_t want;
    bit           idle_on  = 1'b1;
    bit           stall_on = 1'b1;
    int           stall_hold   = 0;
    int           idle_cycles  = 0;
    int           failures     = 0;
    int           samples_sent = 0;
    int           words_seen   = 0;
    int           reg_writes   = 0;
    int           settings_run = 0;
    int           zones_seen [0:4];

    sensor_average_zone_classifier_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average),
        .resistance   (resistance),
        .zone         (zone)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ZONE_BITS-1:0] zone_for(input logic [RES_BITS-1:0] r);
        if (r == set_wet)
            return ZONE_WET;
        if (r > set_upper && res_one_back > set_upper && res_two_back > set_upper)
            return ZONE_SAFE;
        if (r > set_lower && r < set_upper
            && res_one_back > set_lower && res_one_back < set_upper
            && res_two_back > set_lower && res_two_back < set_upper)
            return ZONE_WARNING;
        if (r < set_lower && res_one_back < set_lower && res_two_back < set_lower)
            return ZONE_DANGER;
        return ZONE_NONE;
    endfunction

    // The completing sample is dropped; its quotient seeds the next window.
    function automatic bit average_window(input logic [SAMPLE_BITS-1:0] s,
                                          output window_word_t w);
        int unsigned avg;
        int unsigned res;
        if (win_count < set_count)
        begin
            win_sum   = win_sum + ACC_BITS'(s);
            win_count = win_count + 1'b1;
            return 1'b0;
        end
        avg = win_sum / (int'(set_count) + 1);
        win_sum = avg[ACC_BITS-1:0];
        res = (avg == 0) ? RES_SATURATED : set_numerator / avg;
        w.average    = avg[SAMPLE_BITS-1:0];
        w.resistance = res[RES_BITS-1:0];
        w.zone       = zone_for(res[RES_BITS-1:0]);
        win_count    = '0;
        res_two_back = res_one_back;
        res_one_back = res[RES_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] near_level(input int level);
        int s;
        if (level < 0)
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        s = level + $urandom_range(0, 24) - 12;
        if (s < 0)
            s = 0;
        if (s > SAMPLE_MAX)
            s = SAMPLE_MAX;
        return s[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
        failures++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
        int gap;
        window_word_t w;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
        if (average_window(s, w))
            pending_windows.push_back(w);
    endtask

    task automatic send_window(input int level);
        repeat (int'(set_count) + 1) send_sample(near_level(level));
    endtask

    // Waits for every result word, then lets the block finish any word in hand.
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [RES_BITS-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        unique case (idx)
            REG_SAMPLE_COUNT:    set_count     = data[COUNT_BITS-1:0];
            REG_NUMERATOR:       set_numerator = data;
            REG_UPPER_THRESHOLD: set_upper     = data;
            REG_LOWER_THRESHOLD: set_lower     = data;
            REG_WET_VALUE:       set_wet       = data;
            default: ;
        endcase
        reg_writes++;
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic program_settings(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [RES_BITS-1:0] num, input logic [RES_BITS-1:0] up,
                                    input logic [RES_BITS-1:0] lo, input logic [RES_BITS-1:0] wet);
        write_reg(REG_SAMPLE_COUNT, {{(RES_BITS-COUNT_BITS){1'b0}}, cnt}, 1'b0);
        write_reg(REG_NUMERATOR, num, 1'b0);
        write_reg(REG_UPPER_THRESHOLD, up, 1'b0);
        write_reg(REG_LOWER_THRESHOLD, lo, 1'b0);
        write_reg(REG_WET_VALUE, wet, 1'b1);
        settings_run++;
    endtask

    // Needs a sample count of one: picks the sample that lands the window on target.
    task automatic steer_average(input int target);
        int s;
        s = 2 * target - int'(win_sum);
        if (s < 0)
            s = 0;
        if (s > SAMPLE_MAX)
            s = SAMPLE_MAX;
        send_sample(s[SAMPLE_BITS-1:0]);
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    endtask

    task automatic test_reset_settings();
        repeat (int'(SAMPLE_COUNT_RESET) + 1) send_sample(SAMPLE_BITS'($urandom_range(0, 63)));
        repeat (2 * (int'(SAMPLE_COUNT_RESET) + 1)) send_sample('0);
    endtask

    task automatic test_saturated_wet();
        settle();
        program_settings(8'd1, NUMERATOR_RESET, UPPER_THRESHOLD_RESET, LOWER_THRESHOLD_RESET,
                         RES_SATURATED);
        send_sample('0);
        send_sample('0);
    endtask

    task automatic test_field_extremes();
        int idx;
        settle();
        for (idx = REG_SPARE_FIRST; idx < (1 << INDEX_BITS); idx++)
            write_reg(idx[INDEX_BITS-1:0], RES_BITS'($urandom_range(0, 65535)), 1'b0);
        program_settings(8'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_sample(10'h3FF);
        send_sample(10'h000);
        send_sample(10'h2AA);
        send_sample(10'h155);
    endtask

    task automatic test_zone_bands();
        int t;
        int level;
        settle();
        program_settings(8'd1, NUMERATOR_RESET, UPPER_THRESHOLD_RESET, LOWER_THRESHOLD_RESET,
                         WET_VALUE_RESET);
        for (t = 0; t < 3; t++)
        begin
            level = (t == 0) ? 300 : (t == 1) ? 180 : 100;
            if (t != 0)
            begin
                settle();
                write_reg(REG_SAMPLE_COUNT, 16'd1, 1'b1);
            end
            steer_average(level);
            settle();
            write_reg(REG_SAMPLE_COUNT, 16'd0, 1'b1);
            send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
            send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        end
        settle();
        write_reg(REG_UPPER_THRESHOLD, 16'd100, 1'b0);
        write_reg(REG_LOWER_THRESHOLD, 16'd500, 1'b1);
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        settle();
        write_reg(REG_WET_VALUE, res_one_back, 1'b1);
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    endtask

    task automatic test_counter_past_count();
        settle();
        write_reg(REG_SAMPLE_COUNT, 16'd10, 1'b1);
        repeat (3) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        settle();
        write_reg(REG_SAMPLE_COUNT, 16'd2, 1'b1);
        send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    endtask

    task automatic test_random_settings();
        int r;
        int a;
        int b;
        int level;
        int windows;
        int hold;
        int unsigned num;
        int unsigned up;
        int unsigned lo;
        int unsigned wet;
        int unsigned swap;
        logic [COUNT_BITS-1:0] cnt;
        while (samples_sent < ITEM_TARGET)
        begin
            settle();
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 65)
                cnt = COUNT_BITS'($urandom_range(1, 8));
            else if (r < 80)
                cnt = COUNT_BITS'($urandom_range(9, 40));
            else if (r < 87)
                cnt = 8'd255;
            else if (r < 92)
                cnt = 8'd0;
            else
                cnt = COUNT_BITS'($urandom_range(1, 255));
            r = $urandom_range(0, 99);
            if (r < 60)
                num = $urandom_range(1, 65535);
            else if (r < 75)
                num = NUMERATOR_RESET;
            else if (r < 88)
                num = 65535;
            else
                num = $urandom_range(1, SAMPLE_MAX);
            a = $urandom_range(1, SAMPLE_MAX);
            b = $urandom_range(1, SAMPLE_MAX);
            if (a > b)
            begin
                swap = a;
                a = b;
                b = swap;
            end
            up = num / a;
            lo = num / b;
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                swap = up;
                up = lo;
                lo = swap;
            end
            else if (r < 18)
            begin
                up = 0;
                lo = 65535;
            end
            else if (r < 24)
            begin
                up = 65535;
                lo = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                wet = num / $urandom_range(1, SAMPLE_MAX);
            else if (r < 60)
                wet = RES_SATURATED;
            else
                wet = $urandom_range(0, 65535);
            program_settings(cnt, num[RES_BITS-1:0], up[RES_BITS-1:0], lo[RES_BITS-1:0],
                             wet[RES_BITS-1:0]);
            if (cnt >= 200)
                windows = $urandom_range(1, 2);
            else if (cnt >= 9)
                windows = $urandom_range(2, 6);
            else
                windows = $urandom_range(6, 24);
            hold  = 0;
            level = -1;
            repeat (windows)
            begin
                if (hold == 0)
                begin
                    r = $urandom_range(0, 99);
                    level = (r < 15) ? -1 : (r < 22) ? 0 : $urandom_range(0, SAMPLE_MAX);
                    hold  = $urandom_range(3, 6);
                end
                hold--;
                send_window(level);
            end
            // Leaving a window half full lets the next count land below the counter.
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(0, cnt)) send_sample(near_level(level));
        end
    endtask

    always @(posedge clk)
    begin : result_side
        if (rst_n && result_valid && !result_stall)
        begin
            words_seen++;
            if (zone <= ZONE_DANGER)
                zones_seen[zone]++;
            if (pending_windows.size() == 0)
            begin
                $display("%0t: result word with nothing expected, average %0d resistance %0d zone %0d",
                         $time, average, resistance, zone);
                failures++;
            end
            else
            begin
                want = pending_windows.pop_front();
                if (average !== want.average)
                    report_mismatch("average", want.average, average);
                if (resistance !== want.resistance)
                    report_mismatch("resistance", want.resistance, resistance);
                if (zone !== want.zone)
                    report_mismatch("zone", want.zone, zone);
            end
        end
        if (stall_hold > 0)
            stall_hold--;
        else if (stall_on && $urandom_range(0, 3) == 0)
        begin
            result_stall <= 1'b1;
            stall_hold = pick_gap();
        end
        else
        begin
            result_stall <= 1'b0;
            stall_hold = $urandom_range(0, 4);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sensor_average_zone_classifier_core verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        foreach (zones_seen[z])
            zones_seen[z] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_saturated_wet();
        test_field_extremes();
        test_zone_bands();
        test_counter_past_count();
        test_random_settings();
        settle();
        $display("Sent %0d sample words and checked %0d result words under %0d register settings",
                 samples_sent, words_seen, settings_run);
        $display("(%0d register writes); zones none %0d, wet %0d, safe %0d, warning %0d, danger %0d.",
                 reg_writes, zones_seen[0], zones_seen[1], zones_seen[2], zones_seen[3],
                 zones_seen[4]);
        if (failures == 0 && pending_windows.size() == 0)
            $display("sensor_average_zone_classifier_core verification clean");
        else
            $display("sensor_average_zone_classifier_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sazc_pkg.sv
src/sazc_divider.sv
src/sazc_datapath.sv
src/sazc_ctrl.sv
src/sensor_average_zone_classifier_core.sv
dv/sensor_average_zone_classifier_core_test.sv
